@@ rtl/core/rpwfd_pkg.sv @@
// Package for the three-channel RC pulse-width frame decoder.
// Holds the request and result types, register indexes, widths and the width
// scaling function. No dependencies.
`default_nettype none

package rpwfd_pkg;

	localparam int COUNT_BITS = 8;
	localparam int GAP_BITS   = 8;
	localparam int CFG_BITS   = 8;
	localparam int WIDTH_BITS = 9;
	localparam int IDX_BITS   = 1;

	localparam logic [GAP_BITS-1:0]   GAP_MAX         = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX       = WIDTH_BITS'(510);
	localparam logic [CFG_BITS-1:0]   END_GAP_RESET   = CFG_BITS'(10);
	localparam logic [CFG_BITS-1:0]   MIN_WIDTH_RESET = CFG_BITS'(25);

	// Working widths for doubling and for the minimum check
	localparam int DBL_BITS = (COUNT_BITS + 1 > WIDTH_BITS) ? COUNT_BITS + 1 : WIDTH_BITS;
	localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

	typedef enum logic [IDX_BITS-1:0] {
		REG_END_GAP   = 1'b0,
		REG_MIN_WIDTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic level_a;
		logic level_b;
		logic level_c;
	} in_item_t;

	typedef struct packed {
		logic                  lost;
		logic [WIDTH_BITS-1:0] width_a;
		logic [WIDTH_BITS-1:0] width_b;
		logic [WIDTH_BITS-1:0] width_c;
	} res_item_t;

	// Twice the count, clipped to the largest reportable width
	function automatic logic [WIDTH_BITS-1:0] width_of(input logic [COUNT_BITS-1:0] cnt);
		logic [DBL_BITS-1:0] dbl;
		dbl = DBL_BITS'({cnt, 1'b0});
		if (dbl > DBL_BITS'(WIDTH_MAX))
			return WIDTH_MAX;
		else
			return WIDTH_BITS'(dbl);
	endfunction

	function automatic logic below_min(input logic [COUNT_BITS-1:0] cnt,
	                                   input logic [CFG_BITS-1:0] min_w);
		return CMP_BITS'(cnt) < CMP_BITS'(min_w);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rpwfd_in_stage.sv @@
// Input register stage of the pulse-width frame decoder.
// Depends on rpwfd_pkg for the request type.
`default_nettype none

module rpwfd_in_stage (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  rpwfd_pkg::in_item_t   in_data,
	input  wire                   fire,
	output logic                  valid_s1,
	output rpwfd_pkg::in_item_t   item_s1
);
	import rpwfd_pkg::*;

	logic take;

	// Refill the stage in the same cycle it is drained
	assign in_ready = !valid_s1 || fire;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rpwfd_core.sv @@
// Frame state, channel counters and configuration registers of the decoder.
// Processes one sampled tick per fire; depends on rpwfd_pkg.
`default_nettype none

module rpwfd_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [rpwfd_pkg::IDX_BITS-1:0]     cfg_index,
	input  wire  [rpwfd_pkg::CFG_BITS-1:0]     cfg_data,
	input  wire                                fire,
	input  rpwfd_pkg::in_item_t                item_s1,
	output logic                               push,
	output rpwfd_pkg::res_item_t               push_data
);
	import rpwfd_pkg::*;

	logic                  waiting_q;
	logic                  first_q;
	logic [GAP_BITS-1:0]   gap_q;
	logic [COUNT_BITS-1:0] cnt_a_q;
	logic [COUNT_BITS-1:0] cnt_b_q;
	logic [COUNT_BITS-1:0] cnt_c_q;
	logic [CFG_BITS-1:0]   end_gap_q;
	logic [CFG_BITS-1:0]   min_w_q;

	logic                  any_high;
	logic [GAP_BITS-1:0]   gap_inc;
	logic [CFG_BITS-1:0]   limit;
	logic                  frame_end;
	logic                  lost;
	logic [COUNT_BITS-1:0] base_a;
	logic [COUNT_BITS-1:0] base_b;
	logic [COUNT_BITS-1:0] base_c;
	logic [COUNT_BITS-1:0] nxt_a;
	logic [COUNT_BITS-1:0] nxt_b;
	logic [COUNT_BITS-1:0] nxt_c;

	assign any_high = item_s1.level_a || item_s1.level_b || item_s1.level_c;
	assign gap_inc  = (gap_q == GAP_MAX) ? GAP_MAX : gap_q + GAP_BITS'(1);
	assign limit    = (end_gap_q == '0) ? CFG_BITS'(1) : end_gap_q;
	assign frame_end = !waiting_q && !any_high
		&& ({{(CFG_BITS > GAP_BITS ? CFG_BITS - GAP_BITS : 0){1'b0}}, gap_inc}
		    >= {{(GAP_BITS > CFG_BITS ? GAP_BITS - CFG_BITS : 0){1'b0}}, limit});
	assign lost = below_min(cnt_a_q, min_w_q) || below_min(cnt_b_q, min_w_q)
		|| below_min(cnt_c_q, min_w_q);

	// A new frame starts from cleared counts
	assign base_a = waiting_q ? '0 : cnt_a_q;
	assign base_b = waiting_q ? '0 : cnt_b_q;
	assign base_c = waiting_q ? '0 : cnt_c_q;

	always_comb begin
		nxt_a = base_a;
		nxt_b = base_b;
		nxt_c = base_c;
		priority if (item_s1.level_a) begin
			nxt_a = (base_a == COUNT_MAX) ? COUNT_MAX : base_a + COUNT_BITS'(1);
		end else if (item_s1.level_b) begin
			nxt_b = (base_b == COUNT_MAX) ? COUNT_MAX : base_b + COUNT_BITS'(1);
		end else if (item_s1.level_c) begin
			nxt_c = (base_c == COUNT_MAX) ? COUNT_MAX : base_c + COUNT_BITS'(1);
		end
	end

	assign push = fire && frame_end && (lost || !first_q);

	always_comb begin
		push_data.lost = lost;
		if (lost) begin
			push_data.width_a = '0;
			push_data.width_b = '0;
			push_data.width_c = '0;
		end else begin
			push_data.width_a = width_of(cnt_a_q);
			push_data.width_b = width_of(cnt_b_q);
			push_data.width_c = width_of(cnt_c_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_gap_q <= END_GAP_RESET;
			min_w_q   <= MIN_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_END_GAP:   end_gap_q <= cfg_data;
				REG_MIN_WIDTH: min_w_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			first_q   <= 1'b1;
			gap_q     <= '0;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			cnt_c_q   <= '0;
		end else if (fire) begin
			if (any_high) begin
				waiting_q <= 1'b0;
				gap_q     <= '0;
				cnt_a_q   <= nxt_a;
				cnt_b_q   <= nxt_b;
				cnt_c_q   <= nxt_c;
			end else if (!waiting_q) begin
				gap_q <= gap_inc;
				if (frame_end) begin
					waiting_q <= 1'b1;
					// Drop only the first good frame
					if (!lost) begin
						first_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rpwfd_out_fifo.sv @@
// Two-entry result buffer between the decoder core and the output channel.
// Depends on rpwfd_pkg for the result type.
`default_nettype none

module rpwfd_out_fifo (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  rpwfd_pkg::res_item_t   push_data,
	output logic                   full,
	output logic                   out_valid,
	input  wire                    out_ready,
	output rpwfd_pkg::res_item_t   out_data
);
	import rpwfd_pkg::*;

	res_item_t  mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rc_pulse_width_frame_decoder_top.sv @@
// Three-channel RC pulse-width frame decoder. Each request is one sample tick
// of three channel levels; it takes one tick per clock cycle while the result
// buffer has room, through the input register and the counter update into the
// two-entry result buffer, whose free space is the only thing that holds off
// new ticks. A frame ends after end_gap_ticks all-low ticks and yields either
// a lost flag or three widths (high tick counts times two); the first good
// frame after reset is dropped. Configuration is to be written through the
// plain write port while the block idles; the block does not enforce this.
// Depends on rpwfd_pkg, rpwfd_in_stage, rpwfd_core and rpwfd_out_fifo.
`default_nettype none

module rc_pulse_width_frame_decoder_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  rpwfd_pkg::in_item_t                in_data,
	output logic                               out_valid,
	input  wire                                out_ready,
	output rpwfd_pkg::res_item_t               out_data,
	input  wire                                cfg_we,
	input  wire  [rpwfd_pkg::IDX_BITS-1:0]     cfg_index,
	input  wire  [rpwfd_pkg::CFG_BITS-1:0]     cfg_data
);
	import rpwfd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      fire;
	logic      full;
	logic      push;
	res_item_t push_data;

	assign fire = valid_s1 && !full;

	rpwfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rpwfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item_s1   (item_s1),
		.push      (push),
		.push_data (push_data)
	);

	rpwfd_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.lost) |->
		(out_data.width_a == '0 && out_data.width_b == '0 && out_data.width_c == '0))
		else $error("lost result carries nonzero widths");

	a_width_even: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.lost) |->
		(!out_data.width_a[0] && !out_data.width_b[0] && !out_data.width_c[0]))
		else $error("good result carries an odd width");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into a full buffer");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted request not held in the input stage");

endmodule

`default_nettype wire
